FILE: sv/gamepad_report_remap_macros.svh
// Assertion macros for the controller translator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GAMEPAD_REPORT_REMAP_MACROS_SVH
`define GAMEPAD_REPORT_REMAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GRR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/grr_pkg.sv
// Shared types, constants and the divider step for the controller translator.
// No dependencies; used by every module of the block.
package grr_pkg;

	localparam int NUM_STAGES = 5;

	localparam int BTN_W  = 14;
	localparam int HAT_W  = 4;
	localparam int AXIS_W = 16;
	localparam int OUT_W  = 8;
	localparam int DZ_W   = 15;
	localparam int TRIG_W = 8;
	localparam int NUM_W  = 23;

	// Configuration register indexes
	localparam logic REG_DEAD_ZONE    = 1'b0;
	localparam logic REG_TRIG_THRESH  = 1'b1;

	localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 15'd8000;
	localparam logic [TRIG_W-1:0] TRIG_THRESH_RST = 8'd128;

	// Hat codes
	localparam logic [HAT_W-1:0] HAT_N      = 4'd0;
	localparam logic [HAT_W-1:0] HAT_NE     = 4'd1;
	localparam logic [HAT_W-1:0] HAT_E      = 4'd2;
	localparam logic [HAT_W-1:0] HAT_SE     = 4'd3;
	localparam logic [HAT_W-1:0] HAT_S      = 4'd4;
	localparam logic [HAT_W-1:0] HAT_SW     = 4'd5;
	localparam logic [HAT_W-1:0] HAT_W_DIR  = 4'd6;
	localparam logic [HAT_W-1:0] HAT_NW     = 4'd7;
	localparam logic [HAT_W-1:0] HAT_CENTRE = 4'd8;

	// Axis scaling constants
	localparam logic [AXIS_W-1:0] POS_FULL   = 16'd32767;
	localparam logic [AXIS_W-1:0] NEG_FULL   = 16'd32768;
	localparam logic [OUT_W-1:0]  OUT_CENTRE = 8'd128;
	localparam logic [OUT_W-1:0]  OUT_MAX    = 8'd255;
	localparam logic [OUT_W-1:0]  OUT_MIN    = 8'd0;

	typedef struct packed {
		logic [BTN_W-1:0] buttons;
		logic [HAT_W-1:0] hat;
	} btn_hat_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} stage_ctl_t;

	// One restoring division step: shift in a numerator bit, subtract if it fits.
	// Result is {quotient bit, new remainder}.
	function automatic logic [AXIS_W:0] div_step(input logic [AXIS_W-1:0] rem,
			input logic nbit, input logic [AXIS_W-1:0] den);
		logic [AXIS_W:0] sh;
		logic [AXIS_W:0] diff;
		sh   = {rem, nbit};
		diff = sh - {1'b0, den};
		if (sh >= {1'b0, den}) begin
			div_step = {1'b1, diff[AXIS_W-1:0]};
		end else begin
			div_step = {1'b0, sh[AXIS_W-1:0]};
		end
	endfunction

endpackage

FILE: sv/grr_pipe_ctrl.sv
// Stage valid bits and load enables for the five-stage translator pipeline.
// Depends on grr_pkg and gamepad_report_remap_macros.svh.
`include "gamepad_report_remap_macros.svh"

module grr_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output grr_pkg::stage_ctl_t ctl
);

	logic [grr_pkg::NUM_STAGES-1:0] vld_q;
	logic [grr_pkg::NUM_STAGES-1:0] en;
	logic                           in_acc;
	logic                           out_acc;

	// A stage loads when empty or when the one after it moves on
	always_comb begin
		en[grr_pkg::NUM_STAGES-1] = !vld_q[grr_pkg::NUM_STAGES-1] || out_ready;
		for (int k = grr_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < grr_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[grr_pkg::NUM_STAGES-1];
	assign ctl.en    = en;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	`GRR_ASSERT_NXT(a_item_count, clk, arst_n, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)), "item lost or duplicated in pipeline")
	`GRR_ASSERT_IMP(a_bubble_ready, clk, arst_n, $countones(vld_q) < grr_pkg::NUM_STAGES, in_ready, "input stalled with a free stage")
	`GRR_ASSERT_IMP(a_drain_ready, clk, arst_n, out_ready, in_ready, "input stalled while output drains")

endmodule

FILE: sv/grr_btn_map.sv
// Button remapping, trigger threshold and d-pad to hat encoding.
// Depends on grr_pkg.
module grr_btn_map (
	input  logic [15:0]                    button_mask,
	input  logic [grr_pkg::TRIG_W-1:0]     left_trigger,
	input  logic [grr_pkg::TRIG_W-1:0]     right_trigger,
	input  logic [grr_pkg::TRIG_W-1:0]     trigger_threshold,
	output grr_pkg::btn_hat_t              btn
);

	// Input mask bits
	localparam int M_UP = 0, M_DN = 1, M_LF = 2, M_RG = 3;
	localparam int M_START = 4, M_BACK = 5, M_LTHUMB = 6, M_RTHUMB = 7;
	localparam int M_LSH = 8, M_RSH = 9, M_A = 12, M_B = 13, M_X = 14, M_Y = 15;
	// Report bits
	localparam int R_Y = 0, R_B = 1, R_A = 2, R_X = 3, R_L = 4, R_R = 5;
	localparam int R_ZL = 6, R_ZR = 7, R_MINUS = 8, R_PLUS = 9;
	localparam int R_LSTICK = 10, R_RSTICK = 11, R_HOME = 12, R_CAPTURE = 13;

	logic home;
	logic capture;
	logic up, dn, lf, rg;

	assign home    = button_mask[M_LTHUMB] && button_mask[M_RTHUMB];
	assign capture = button_mask[M_BACK] && button_mask[M_START];
	assign up      = button_mask[M_UP];
	assign dn      = button_mask[M_DN];
	assign lf      = button_mask[M_LF];
	assign rg      = button_mask[M_RG];

	always_comb begin
		btn.buttons            = '0;
		btn.buttons[R_Y]       = button_mask[M_X];
		btn.buttons[R_B]       = button_mask[M_A];
		btn.buttons[R_A]       = button_mask[M_B];
		btn.buttons[R_X]       = button_mask[M_Y];
		btn.buttons[R_L]       = button_mask[M_LSH];
		btn.buttons[R_R]       = button_mask[M_RSH];
		btn.buttons[R_ZL]      = left_trigger > trigger_threshold;
		btn.buttons[R_ZR]      = right_trigger > trigger_threshold;
		// combos replace their component buttons
		btn.buttons[R_MINUS]   = button_mask[M_BACK] && !capture;
		btn.buttons[R_PLUS]    = button_mask[M_START] && !capture;
		btn.buttons[R_LSTICK]  = button_mask[M_LTHUMB] && !home;
		btn.buttons[R_RSTICK]  = button_mask[M_RTHUMB] && !home;
		btn.buttons[R_HOME]    = home;
		btn.buttons[R_CAPTURE] = capture;

		// diagonals first, then single directions
		priority if (up && rg) begin
			btn.hat = grr_pkg::HAT_NE;
		end else if (up && lf) begin
			btn.hat = grr_pkg::HAT_NW;
		end else if (dn && rg) begin
			btn.hat = grr_pkg::HAT_SE;
		end else if (dn && lf) begin
			btn.hat = grr_pkg::HAT_SW;
		end else if (up) begin
			btn.hat = grr_pkg::HAT_N;
		end else if (dn) begin
			btn.hat = grr_pkg::HAT_S;
		end else if (lf) begin
			btn.hat = grr_pkg::HAT_W_DIR;
		end else if (rg) begin
			btn.hat = grr_pkg::HAT_E;
		end else begin
			btn.hat = grr_pkg::HAT_CENTRE;
		end
	end

endmodule

FILE: sv/grr_axis.sv
// Five-stage dead-zone and scaling datapath for one stick axis.
// Depends on grr_pkg; stage enables come from grr_pipe_ctrl.
module grr_axis (
	input  logic                              clk,
	input  grr_pkg::stage_ctl_t               ctl,
	input  logic [grr_pkg::DZ_W-1:0]          dead_zone,
	input  logic                              invert,
	input  logic signed [grr_pkg::AXIS_W-1:0] axis_in,
	output logic [grr_pkg::OUT_W-1:0]         axis_out
);

	localparam int AW = grr_pkg::AXIS_W;
	localparam int NW = grr_pkg::NUM_W;
	localparam int OW = grr_pkg::OUT_W;

	// stage 1: classify and form numerator factor and divisor
	logic signed [AW:0] vx, dx, dpos, mag, dneg;
	logic [AW-1:0]      den_pos, den_neg;
	logic               band_c, pos_c;

	logic [AW-1:0] diff_s1, den_s1;
	logic          pos_s1, band_s1, sat_s1;

	always_comb begin
		vx      = {axis_in[AW-1], axis_in};
		dx      = signed'({2'b00, dead_zone});
		band_c  = (vx > -dx) && (vx < dx);
		pos_c   = vx >= dx;
		dpos    = vx - dx;
		mag     = -vx;
		dneg    = mag - dx;
		den_pos = grr_pkg::POS_FULL - {1'b0, dead_zone};
		den_neg = grr_pkg::NEG_FULL - {1'b0, dead_zone};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			diff_s1 <= pos_c ? dpos[AW-1:0] : dneg[AW-1:0];
			den_s1  <= pos_c ? den_pos : den_neg;
			pos_s1  <= pos_c;
			band_s1 <= band_c;
			sat_s1  <= pos_c && (den_pos == '0);
		end
	end

	// stage 2: numerator, times 127 on the positive side and 128 on the negative
	logic [NW-1:0] num_s2;
	logic [AW-1:0] den_s2;
	logic          pos_s2, band_s2, sat_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			num_s2  <= pos_s1 ? ({diff_s1, 7'b0} - {7'b0, diff_s1}) : {diff_s1, 7'b0};
			den_s2  <= den_s1;
			pos_s2  <= pos_s1;
			band_s2 <= band_s1;
			sat_s2  <= sat_s1;
		end
	end

	// stage 3: quotient bits 7..5 (quotient is known to fit in eight bits)
	logic [AW:0]   st3_a, st3_b, st3_c;
	logic [AW-1:0] rem_s3, den_s3;
	logic [2:0]    q_s3;
	logic [4:0]    low_s3;
	logic          pos_s3, band_s3, sat_s3;

	always_comb begin
		st3_a = grr_pkg::div_step({1'b0, num_s2[NW-1:8]}, num_s2[7], den_s2);
		st3_b = grr_pkg::div_step(st3_a[AW-1:0], num_s2[6], den_s2);
		st3_c = grr_pkg::div_step(st3_b[AW-1:0], num_s2[5], den_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			rem_s3  <= st3_c[AW-1:0];
			q_s3    <= {st3_a[AW], st3_b[AW], st3_c[AW]};
			low_s3  <= num_s2[4:0];
			den_s3  <= den_s2;
			pos_s3  <= pos_s2;
			band_s3 <= band_s2;
			sat_s3  <= sat_s2;
		end
	end

	// stage 4: quotient bits 4..2
	logic [AW:0]   st4_a, st4_b, st4_c;
	logic [AW-1:0] rem_s4, den_s4;
	logic [5:0]    q_s4;
	logic [1:0]    low_s4;
	logic          pos_s4, band_s4, sat_s4;

	always_comb begin
		st4_a = grr_pkg::div_step(rem_s3, low_s3[4], den_s3);
		st4_b = grr_pkg::div_step(st4_a[AW-1:0], low_s3[3], den_s3);
		st4_c = grr_pkg::div_step(st4_b[AW-1:0], low_s3[2], den_s3);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			rem_s4  <= st4_c[AW-1:0];
			q_s4    <= {q_s3, st4_a[AW], st4_b[AW], st4_c[AW]};
			low_s4  <= low_s3[1:0];
			den_s4  <= den_s3;
			pos_s4  <= pos_s3;
			band_s4 <= band_s3;
			sat_s4  <= sat_s3;
		end
	end

	// stage 5: last two quotient bits, offset from centre, clamp, invert, and centre inside the dead band
	logic [AW:0]   st5_a, st5_b;
	logic [OW-1:0] quo;
	logic [OW:0]   sum_c, dif_c;
	logic [OW-1:0] scaled;
	logic [OW-1:0] axis_s5;

	always_comb begin
		st5_a = grr_pkg::div_step(rem_s4, low_s4[1], den_s4);
		st5_b = grr_pkg::div_step(st5_a[AW-1:0], low_s4[0], den_s4);
		quo   = {q_s4, st5_a[AW], st5_b[AW]};
		sum_c = {1'b0, grr_pkg::OUT_CENTRE} + {1'b0, quo};
		dif_c = {1'b0, grr_pkg::OUT_CENTRE} - {1'b0, quo};
		if (sat_s4) begin
			scaled = grr_pkg::OUT_MAX;
		end else if (pos_s4) begin
			scaled = sum_c[OW] ? grr_pkg::OUT_MAX : sum_c[OW-1:0];
		end else begin
			scaled = dif_c[OW] ? grr_pkg::OUT_MIN : dif_c[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			if (band_s4) begin
				axis_s5 <= grr_pkg::OUT_CENTRE;
			end else if (invert) begin
				axis_s5 <= grr_pkg::OUT_MAX - scaled;
			end else begin
				axis_s5 <= scaled;
			end
		end
	end

	assign axis_out = axis_s5;

endmodule

FILE: sv/gamepad_report_remap.sv
// Top level of the controller sample to report translator.
// Depends on grr_pkg, grr_pipe_ctrl, grr_btn_map and grr_axis.
//
// Takes one controller sample per cycle, for as long as out_ready stays high, and
// returns one report per accepted sample. The stages follow the axis path: range
// check, numerator, then an eight-bit restoring divider spread over three stages,
// with the last stage doubling as the output register.
// Stages fill bubbles on their own, so in_ready falls only when all five hold an
// item and out_ready is low; in_ready follows out_ready combinationally.
// Configuration writes take effect on the next sample and belong to idle time.
module gamepad_report_remap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [grr_pkg::DZ_W-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [15:0]                       button_mask,
	input  logic [grr_pkg::TRIG_W-1:0]        left_trigger,
	input  logic [grr_pkg::TRIG_W-1:0]        right_trigger,
	input  logic signed [grr_pkg::AXIS_W-1:0] left_stick_x,
	input  logic signed [grr_pkg::AXIS_W-1:0] left_stick_y,
	input  logic signed [grr_pkg::AXIS_W-1:0] right_stick_x,
	input  logic signed [grr_pkg::AXIS_W-1:0] right_stick_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [grr_pkg::BTN_W-1:0]         report_buttons,
	output logic [grr_pkg::HAT_W-1:0]         hat_direction,
	output logic [grr_pkg::OUT_W-1:0]         left_x_out,
	output logic [grr_pkg::OUT_W-1:0]         left_y_out,
	output logic [grr_pkg::OUT_W-1:0]         right_x_out,
	output logic [grr_pkg::OUT_W-1:0]         right_y_out
);

	logic [grr_pkg::DZ_W-1:0]   dead_zone_q;
	logic [grr_pkg::TRIG_W-1:0] trig_thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= grr_pkg::DEAD_ZONE_RST;
			trig_thresh_q <= grr_pkg::TRIG_THRESH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				grr_pkg::REG_DEAD_ZONE: begin
					dead_zone_q <= cfg_data;
				end
				grr_pkg::REG_TRIG_THRESH: begin
					trig_thresh_q <= cfg_data[grr_pkg::TRIG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	grr_pkg::stage_ctl_t ctl;

	grr_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Buttons and hat are done in the first stage; carry them alongside the axes
	grr_pkg::btn_hat_t btn_c;
	grr_pkg::btn_hat_t btn_s1, btn_s2, btn_s3, btn_s4, btn_s5;

	grr_btn_map u_btn (
		.button_mask       (button_mask),
		.left_trigger      (left_trigger),
		.right_trigger     (right_trigger),
		.trigger_threshold (trig_thresh_q),
		.btn               (btn_c)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			btn_s1 <= btn_c;
		end
		if (ctl.en[1]) begin
			btn_s2 <= btn_s1;
		end
		if (ctl.en[2]) begin
			btn_s3 <= btn_s2;
		end
		if (ctl.en[3]) begin
			btn_s4 <= btn_s3;
		end
		if (ctl.en[4]) begin
			btn_s5 <= btn_s4;
		end
	end

	assign report_buttons = btn_s5.buttons;
	assign hat_direction  = btn_s5.hat;

	grr_axis u_left_x (
		.clk       (clk),
		.ctl       (ctl),
		.dead_zone (dead_zone_q),
		.invert    (1'b0),
		.axis_in   (left_stick_x),
		.axis_out  (left_x_out)
	);

	grr_axis u_left_y (
		.clk       (clk),
		.ctl       (ctl),
		.dead_zone (dead_zone_q),
		.invert    (1'b1),
		.axis_in   (left_stick_y),
		.axis_out  (left_y_out)
	);

	grr_axis u_right_x (
		.clk       (clk),
		.ctl       (ctl),
		.dead_zone (dead_zone_q),
		.invert    (1'b0),
		.axis_in   (right_stick_x),
		.axis_out  (right_x_out)
	);

	grr_axis u_right_y (
		.clk       (clk),
		.ctl       (ctl),
		.dead_zone (dead_zone_q),
		.invert    (1'b1),
		.axis_in   (right_stick_y),
		.axis_out  (right_y_out)
	);

endmodule

FILE: tb/sv/gamepad_report_remap_test.sv
// Self-checking testbench for the controller sample to report translator.
// Depends on grr_pkg and gamepad_report_remap; drives random and edge-case samples
// under several register settings and checks every report against its own predictor.
module gamepad_report_remap_test;
	import grr_pkg::*;

	localparam int ITEMS_PER_PHASE = 90;
	localparam int NUM_PHASES      = 6;
	localparam int STALL_LIMIT     = 2000;

	// Input mask bit positions
	localparam int PAD_UP     = 0;
	localparam int PAD_DOWN   = 1;
	localparam int PAD_LEFT   = 2;
	localparam int PAD_RIGHT  = 3;
	localparam int KEY_START  = 4;
	localparam int KEY_BACK   = 5;
	localparam int THUMB_L    = 6;
	localparam int THUMB_R    = 7;
	localparam int SHOULDER_L = 8;
	localparam int SHOULDER_R = 9;
	localparam int FACE_A     = 12;
	localparam int FACE_B     = 13;
	localparam int FACE_X     = 14;
	localparam int FACE_Y     = 15;

	// Report button bit positions
	localparam int RPT_Y       = 0;
	localparam int RPT_B       = 1;
	localparam int RPT_A       = 2;
	localparam int RPT_X       = 3;
	localparam int RPT_L       = 4;
	localparam int RPT_R       = 5;
	localparam int RPT_ZL      = 6;
	localparam int RPT_ZR      = 7;
	localparam int RPT_MINUS   = 8;
	localparam int RPT_PLUS    = 9;
	localparam int RPT_LSTICK  = 10;
	localparam int RPT_RSTICK  = 11;
	localparam int RPT_HOME    = 12;
	localparam int RPT_CAPTURE = 13;

	typedef struct packed {
		logic [15:0]              mask;
		logic [TRIG_W-1:0]        lt;
		logic [TRIG_W-1:0]        rt;
		logic signed [AXIS_W-1:0] lx;
		logic signed [AXIS_W-1:0] ly;
		logic signed [AXIS_W-1:0] rx;
		logic signed [AXIS_W-1:0] ry;
	} sample_t;

	typedef struct packed {
		logic [BTN_W-1:0] buttons;
		logic [HAT_W-1:0] hat;
		logic [OUT_W-1:0] lx;
		logic [OUT_W-1:0] ly;
		logic [OUT_W-1:0] rx;
		logic [OUT_W-1:0] ry;
	} report_t;

	class expected_reports;
		logic [DZ_W-1:0]   dead_zone;
		logic [TRIG_W-1:0] trig_threshold;
		report_t           pending_reports[$];
		int                mismatches;
		int                samples_seen;
		int                reports_seen;

		function new();
			dead_zone      = DEAD_ZONE_RST;
			trig_threshold = TRIG_THRESH_RST;
			mismatches     = 0;
			samples_seen   = 0;
			reports_seen   = 0;
		endfunction

		function void set_register(logic idx, logic [DZ_W-1:0] value);
			if (idx == REG_DEAD_ZONE) begin
				dead_zone = value;
			end else begin
				trig_threshold = value[TRIG_W-1:0];
			end
		endfunction

		function logic [OUT_W-1:0] scale_stick(logic signed [AXIS_W-1:0] v, bit invert);
			int val;
			int d;
			int s;
			val = v;
			d = dead_zone;
			if (val > -d && val < d) begin
				return OUT_CENTRE;
			end
			if (val >= d) begin
				// full dead zone leaves no span above it: saturate
				s = (32767 - d > 0) ? 128 + ((val - d) * 127) / (32767 - d) : 255;
			end else begin
				s = 128 - ((-val - d) * 128) / (32768 - d);
			end
			if (s < 0) s = 0;
			if (s > 255) s = 255;
			return invert ? OUT_W'(255 - s) : OUT_W'(s);
		endfunction

		function report_t translate_sample(sample_t s);
			report_t r;
			logic up, dn, lf, rg;
			r.buttons = '0;
			r.buttons[RPT_B]      = s.mask[FACE_A];
			r.buttons[RPT_A]      = s.mask[FACE_B];
			r.buttons[RPT_Y]      = s.mask[FACE_X];
			r.buttons[RPT_X]      = s.mask[FACE_Y];
			r.buttons[RPT_L]      = s.mask[SHOULDER_L];
			r.buttons[RPT_R]      = s.mask[SHOULDER_R];
			r.buttons[RPT_ZL]     = s.lt > trig_threshold;
			r.buttons[RPT_ZR]     = s.rt > trig_threshold;
			r.buttons[RPT_MINUS]  = s.mask[KEY_BACK];
			r.buttons[RPT_PLUS]   = s.mask[KEY_START];
			r.buttons[RPT_LSTICK] = s.mask[THUMB_L];
			r.buttons[RPT_RSTICK] = s.mask[THUMB_R];
			if (s.mask[THUMB_L] && s.mask[THUMB_R]) begin
				r.buttons[RPT_HOME]   = 1'b1;
				r.buttons[RPT_LSTICK] = 1'b0;
				r.buttons[RPT_RSTICK] = 1'b0;
			end
			if (s.mask[KEY_BACK] && s.mask[KEY_START]) begin
				r.buttons[RPT_CAPTURE] = 1'b1;
				r.buttons[RPT_MINUS]   = 1'b0;
				r.buttons[RPT_PLUS]    = 1'b0;
			end
			up = s.mask[PAD_UP];
			dn = s.mask[PAD_DOWN];
			lf = s.mask[PAD_LEFT];
			rg = s.mask[PAD_RIGHT];
			// diagonals win, then single directions in fixed order
			if (up && rg)      r.hat = HAT_NE;
			else if (up && lf) r.hat = HAT_NW;
			else if (dn && rg) r.hat = HAT_SE;
			else if (dn && lf) r.hat = HAT_SW;
			else if (up)       r.hat = HAT_N;
			else if (dn)       r.hat = HAT_S;
			else if (lf)       r.hat = HAT_W_DIR;
			else if (rg)       r.hat = HAT_E;
			else               r.hat = HAT_CENTRE;
			r.lx = scale_stick(s.lx, 1'b0);
			r.ly = scale_stick(s.ly, 1'b1);
			r.rx = scale_stick(s.rx, 1'b0);
			r.ry = scale_stick(s.ry, 1'b1);
			return r;
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("%0t: mismatch: %s", $realtime, what);
		endtask

		function int pending();
			return pending_reports.size();
		endfunction

		task note_sample(sample_t s);
			samples_seen++;
			pending_reports.push_back(translate_sample(s));
		endtask

		task check_report(report_t got);
			report_t want;
			reports_seen++;
			if (pending_reports.size() == 0) begin
				flag_mismatch("report with no sample waiting");
				return;
			end
			want = pending_reports.pop_front();
			if (got.buttons !== want.buttons)
				flag_mismatch($sformatf("report_buttons %h, want %h", got.buttons, want.buttons));
			if (got.hat !== want.hat)
				flag_mismatch($sformatf("hat_direction %0d, want %0d", got.hat, want.hat));
			if (got.lx !== want.lx)
				flag_mismatch($sformatf("left_x_out %0d, want %0d", got.lx, want.lx));
			if (got.ly !== want.ly)
				flag_mismatch($sformatf("left_y_out %0d, want %0d", got.ly, want.ly));
			if (got.rx !== want.rx)
				flag_mismatch($sformatf("right_x_out %0d, want %0d", got.rx, want.rx));
			if (got.ry !== want.ry)
				flag_mismatch($sformatf("right_y_out %0d, want %0d", got.ry, want.ry));
		endtask

		task flush_leftovers();
			while (pending_reports.size() != 0) begin
				void'(pending_reports.pop_front());
				flag_mismatch("expected report never arrived");
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic                     cfg_index;
	logic [DZ_W-1:0]          cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [15:0]              button_mask;
	logic [TRIG_W-1:0]        left_trigger;
	logic [TRIG_W-1:0]        right_trigger;
	logic signed [AXIS_W-1:0] left_stick_x;
	logic signed [AXIS_W-1:0] left_stick_y;
	logic signed [AXIS_W-1:0] right_stick_x;
	logic signed [AXIS_W-1:0] right_stick_y;
	logic                     out_valid;
	logic                     out_ready;
	logic [BTN_W-1:0]         report_buttons;
	logic [HAT_W-1:0]         hat_direction;
	logic [OUT_W-1:0]         left_x_out;
	logic [OUT_W-1:0]         left_y_out;
	logic [OUT_W-1:0]         right_x_out;
	logic [OUT_W-1:0]         right_y_out;

	expected_reports sb = new();
	bit  pace;
	int  quiet_cycles;
	int  settings_used;

	gamepad_report_remap DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_mask    (button_mask),
		.left_trigger   (left_trigger),
		.right_trigger  (right_trigger),
		.left_stick_x   (left_stick_x),
		.left_stick_y   (left_stick_y),
		.right_stick_x  (right_stick_x),
		.right_stick_y  (right_stick_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.report_buttons (report_buttons),
		.hat_direction  (hat_direction),
		.left_x_out     (left_x_out),
		.left_y_out     (left_y_out),
		.right_x_out    (right_x_out),
		.right_y_out    (right_y_out)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random while pacing is on
	always @(negedge clk) begin
		out_ready = !pace || ($urandom_range(99) >= 35);
	end

	// Monitor both channels
	always @(posedge clk) begin
		sample_t s;
		report_t r;
		if (arst_n && in_valid && in_ready) begin
			s = '{button_mask, left_trigger, right_trigger,
				left_stick_x, left_stick_y, right_stick_x, right_stick_y};
			sb.note_sample(s);
		end
		if (arst_n && out_valid && out_ready) begin
			r = '{report_buttons, hat_direction, left_x_out, left_y_out,
				right_x_out, right_y_out};
			sb.check_report(r);
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("gamepad_report_remap test failed");
				$finish;
			end
		end
	end

	task send_sample(sample_t s);
		@(negedge clk);
		while (pace && $urandom_range(99) < 35) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		button_mask   = s.mask;
		left_trigger  = s.lt;
		right_trigger = s.rt;
		left_stick_x  = s.lx;
		left_stick_y  = s.ly;
		right_stick_x = s.rx;
		right_stick_y = s.ry;
		in_valid      = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold the sender until every outstanding report is back
	task drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [DZ_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function logic signed [AXIS_W-1:0] pick_axis();
		int d;
		d = sb.dead_zone;
		case ($urandom_range(9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			3: return AXIS_W'(d);
			4: return AXIS_W'(d - 1);
			5: return AXIS_W'(-d);
			6: return AXIS_W'(-d + 1);
			7: return AXIS_W'(int'($urandom_range(d)) - int'($urandom_range(d)));
			default: return AXIS_W'($urandom);
		endcase
	endfunction

	function logic [TRIG_W-1:0] pick_trigger();
		if ($urandom_range(1) == 0) begin
			return TRIG_W'($urandom);
		end
		return TRIG_W'(int'(sb.trig_threshold) + int'($urandom_range(2)) - 1);
	endfunction

	function sample_t random_sample();
		sample_t s;
		s.mask = 16'($urandom);
		case ($urandom_range(3))
			1: s.mask[THUMB_R:THUMB_L] = 2'b11;
			2: s.mask[KEY_BACK:KEY_START] = 2'b11;
			3: s.mask[15:4] = '0;
			default: ;
		endcase
		s.lt = pick_trigger();
		s.rt = pick_trigger();
		s.lx = pick_axis();
		s.ly = pick_axis();
		s.rx = pick_axis();
		s.ry = pick_axis();
		return s;
	endfunction

	// Samples right on the band edges and trigger threshold of the current setting
	task send_edges();
		sample_t s;
		int d;
		d = sb.dead_zone;
		s = '{16'h0000, sb.trig_threshold, TRIG_W'(int'(sb.trig_threshold) + 1),
			AXIS_W'(d), AXIS_W'(-d), AXIS_W'(d - 1), 16'sd32767};
		send_sample(s);
		s = '{16'hFFFF, TRIG_W'(int'(sb.trig_threshold) + 1), sb.trig_threshold,
			16'sd0, -16'sd32768, AXIS_W'(-d + 1), -16'sd1};
		send_sample(s);
	endtask

	task send_directed();
		sample_t s;
		int edges[16];
		edges = '{-32768, 32767, 0, 7999, 8000, -7999, -8000, 1,
			-1, 32766, -32767, 8001, -8001, 16000, -16000, 100};
		// walk every d-pad combination, one face button each, every combo pair
		for (int i = 0; i < 16; i++) begin
			s.mask = {4'(1 << (i % 4)), 2'(i), 2'(i >> 2), 2'(i), 2'(i >> 1), 4'(i)};
			s.lt = TRIG_W'(128 + (i % 2));
			s.rt = TRIG_W'(129 - (i % 2));
			s.lx = AXIS_W'(edges[i]);
			s.ly = AXIS_W'(edges[(i + 5) % 16]);
			s.rx = AXIS_W'(edges[(i + 10) % 16]);
			s.ry = AXIS_W'(edges[(i + 15) % 16]);
			send_sample(s);
		end
		send_sample('{16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		send_sample('{16'hFFFF, 8'd255, 8'd255, 16'sd32767, -16'sd32768,
			-16'sd32768, 16'sd32767});
	endtask

	initial begin
		logic [DZ_W-1:0]   dz;
		logic [TRIG_W-1:0] th;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_DEAD_ZONE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		out_ready     = 1'b0;
		button_mask   = '0;
		left_trigger  = '0;
		right_trigger = '0;
		left_stick_x  = '0;
		left_stick_y  = '0;
		right_stick_x = '0;
		right_stick_y = '0;
		pace          = 1'b1;
		quiet_cycles  = 0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_directed();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin dz = '0; th = '0; end
					2: begin dz = 15'd32767; th = 8'd255; end
					3: begin dz = 15'd32766; th = TRIG_W'($urandom); end
					4: begin dz = DZ_W'($urandom_range(32767)); th = TRIG_W'($urandom); end
					default: begin dz = 15'd1; th = 8'd1; end
				endcase
				write_reg(REG_DEAD_ZONE, dz);
				write_reg(REG_TRIG_THRESH, {7'd0, th});
				settings_used++;
			end
			send_edges();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// back-to-back stretch with no random stalls on either side (the mid-phase drain still idles the sender)
				pace = !(n >= 30 && n < 70);
				if (n == ITEMS_PER_PHASE / 2) begin
					drain();
				end
				send_sample(random_sample());
			end
			pace = 1'b1;
		end

		drain();
		repeat (10) @(posedge clk);
		sb.flush_leftovers();
		$display("covered %0d samples and %0d reports over %0d register settings",
			sb.samples_seen, sb.reports_seen, settings_used);
		if (sb.mismatches == 0) begin
			$display("gamepad_report_remap test passed");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("gamepad_report_remap test failed");
		end
		$finish;
	end

endmodule
